// ----- rtl/amrr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// amrr_pkg
// Shared types and constants of the AMRR rate controller.
// ----------------------------------------------------------------------------
package amrr_pkg;

	// operation codes as they arrive on the item channel
	localparam logic [1:0] OP_FRAME   = 2'd0;
	localparam logic [1:0] OP_TICK    = 2'd1;
	localparam logic [1:0] OP_RESTART = 2'd2;
	localparam logic [1:0] OP_NONE    = 2'd3;

	// configuration register indexes
	localparam int          CFG_IDX_W   = 2;
	localparam logic [1:0]  CFG_MIN_THR = 2'd0;
	localparam logic [1:0]  CFG_MAX_THR = 2'd1;
	localparam logic [1:0]  CFG_NUM_RT  = 2'd2;
	localparam int          CFG_DATA_W  = 8;

	localparam logic [7:0]  MIN_THR_RST = 8'd1;
	localparam logic [7:0]  MAX_THR_RST = 8'd10;
	localparam logic [4:0]  NUM_RT_RST  = 5'd12;

	localparam int          QUEUE_DEPTH = 2;

	// classified item held in the queue
	typedef struct packed {
		logic [1:0] op;
		logic       retried;
		logic [3:0] start_rate;
	} amrr_item_t;

	typedef struct packed {
		logic [7:0] min_thr;
		logic [7:0] max_thr;
		logic [4:0] num_rates;
	} amrr_cfg_t;

endpackage
`default_nettype wire

// ----- rtl/amrr_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// amrr_if
// Valid/ready channels of the AMRR rate controller: items, results, config.
// ----------------------------------------------------------------------------
interface amrr_in_if import amrr_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [3:0] short_retries;
	logic [3:0] long_retries;
	logic [3:0] start_rate;

	modport source (output valid, operation, short_retries, long_retries, start_rate,
		input ready);
	modport sink (input valid, operation, short_retries, long_retries, start_rate,
		output ready);
endinterface

interface amrr_out_if import amrr_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [3:0] rate_index;
	logic       rate_changed;
	logic [7:0] current_threshold;
	logic       in_recovery;

	modport source (output valid, rate_index, rate_changed, current_threshold, in_recovery,
		input ready);
	modport sink (input valid, rate_index, rate_changed, current_threshold, in_recovery,
		output ready);
endinterface

interface amrr_cfg_if import amrr_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/amrr_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// amrr_front
// Accept items while the queue has room and classify them for the back end.
// ----------------------------------------------------------------------------
module amrr_front import amrr_pkg::*; (
	amrr_in_if.sink    items,
	input  wire logic  q_full,
	output logic       q_push,
	output amrr_item_t q_item
);

	assign items.ready = !q_full;
	assign q_push      = items.valid && !q_full;

	// reduce the retry counts to one flag; only the frame count cares
	always_comb begin
		q_item.op         = items.operation;
		q_item.retried    = |{items.short_retries, items.long_retries};
		q_item.start_rate = items.start_rate;
	end

endmodule
`default_nettype wire

// ----- rtl/amrr_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// amrr_queue
// Short FIFO of classified items between front and back end.
// ----------------------------------------------------------------------------
module amrr_queue import amrr_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire amrr_item_t  wr_item,
	input  wire logic        pop,
	output logic             full,
	output logic             valid,
	output amrr_item_t       rd_item
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	amrr_item_t         entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full    = (count_q == CNT_W'(QUEUE_DEPTH));
	assign valid   = (count_q != '0);
	assign rd_item = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/amrr_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// amrr_back
// Execute queued items against the link state and register one result each.
// ----------------------------------------------------------------------------
module amrr_back import amrr_pkg::*; #(
	parameter int COUNT_WIDTH = 16,
	parameter int MAX_RATES   = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire amrr_cfg_t  cfg,
	input  wire logic       q_valid,
	input  wire amrr_item_t q_item,
	output logic            q_pop,
	amrr_out_if.source      results
);

	localparam int         LIM   = (MAX_RATES < 16) ? MAX_RATES : 16;
	localparam logic [4:0] LIM_V = 5'(LIM);
	localparam int         CW    = COUNT_WIDTH;

	logic [3:0]    rate_q;
	logic [CW-1:0] sent_q;
	logic [CW-1:0] retried_q;
	logic [7:0]    succ_q;
	logic [7:0]    thr_q;
	logic          rec_q;

	logic          res_valid_q;
	logic [3:0]    res_rate_q;
	logic          res_changed_q;
	logic [7:0]    res_thr_q;
	logic          res_rec_q;

	logic [3:0]    rate_d;
	logic [CW-1:0] sent_d;
	logic [CW-1:0] retried_d;
	logic [7:0]    succ_d;
	logic [7:0]    thr_d;
	logic          rec_d;

	logic [4:0]    lim_eff;
	logic [4:0]    lim_nz;
	logic [3:0]    top_rate;
	logic          enough;
	logic          good;
	logic          bad;
	logic [CW:0]   retried_p1;
	logic [CW+3:0] ten_times;
	logic [CW+1:0] three_times;
	logic [7:0]    succ_inc;
	logic [8:0]    thr_dbl;

	// a new item runs when the result register is free or drains this cycle
	assign q_pop = q_valid && (!res_valid_q || results.ready);

	always_comb begin
		lim_eff  = (cfg.num_rates < LIM_V) ? cfg.num_rates : LIM_V;
		lim_nz   = (lim_eff == 5'd0) ? 5'd1 : lim_eff;
		top_rate = 4'(lim_nz - 5'd1);
	end

	// retried < sent/10  <=>  10*(retried+1) <= sent
	// retried > sent/3   <=>  3*retried > sent
	always_comb begin
		retried_p1  = {1'b0, retried_q} + 1'b1;
		ten_times   = {2'b00, retried_p1, 1'b0} + {retried_p1, 3'b000};
		three_times = {1'b0, retried_q, 1'b0} + {2'b00, retried_q};
		enough      = (sent_q > CW'(10));
		good        = (ten_times <= {4'b0000, sent_q});
		bad         = (three_times > {2'b00, sent_q});
		succ_inc    = (succ_q == 8'hFF) ? succ_q : succ_q + 1'b1;
		thr_dbl     = {thr_q, 1'b0};
	end

	always_comb begin
		rate_d    = rate_q;
		sent_d    = sent_q;
		retried_d = retried_q;
		succ_d    = succ_q;
		thr_d     = thr_q;
		rec_d     = rec_q;
		case (q_item.op)
			OP_FRAME: begin
				if (sent_q != '1) begin
					sent_d = sent_q + 1'b1;
				end
				if (q_item.retried && (retried_q != '1)) begin
					retried_d = retried_q + 1'b1;
				end
			end
			OP_TICK: begin
				if (good && enough) begin
					if ((succ_inc >= thr_q) && (rate_q < top_rate)) begin
						rec_d  = 1'b1;
						succ_d = '0;
						rate_d = rate_q + 1'b1;
					end else begin
						rec_d  = 1'b0;
						succ_d = succ_inc;
					end
				end else if (bad) begin
					succ_d = '0;
					if (rate_q != 4'd0) begin
						if (rec_q) begin
							thr_d = (thr_dbl < {1'b0, cfg.max_thr}) ? thr_dbl[7:0] : cfg.max_thr;
						end else begin
							thr_d = cfg.min_thr;
						end
						rate_d = rate_q - 1'b1;
					end
					rec_d = 1'b0;
				end
				if (enough || (rate_d != rate_q)) begin
					sent_d    = '0;
					retried_d = '0;
				end
			end
			OP_RESTART: begin
				rate_d    = (q_item.start_rate > top_rate) ? top_rate : q_item.start_rate;
				sent_d    = '0;
				retried_d = '0;
				succ_d    = '0;
				rec_d     = 1'b0;
				thr_d     = cfg.min_thr;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q      <= '0;
			sent_q      <= '0;
			retried_q   <= '0;
			succ_q      <= '0;
			thr_q       <= MIN_THR_RST;
			rec_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				rate_q      <= rate_d;
				sent_q      <= sent_d;
				retried_q   <= retried_d;
				succ_q      <= succ_d;
				thr_q       <= thr_d;
				rec_q       <= rec_d;
				res_valid_q <= 1'b1;
			end else if (results.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			res_rate_q    <= rate_d;
			res_changed_q <= (rate_d != rate_q);
			res_thr_q     <= thr_d;
			res_rec_q     <= rec_d;
		end
	end

	assign results.valid             = res_valid_q;
	assign results.rate_index        = res_rate_q;
	assign results.rate_changed      = res_changed_q;
	assign results.current_threshold = res_thr_q;
	assign results.in_recovery       = res_rec_q;

endmodule
`default_nettype wire

// ----- rtl/amrr_rate_adaptation.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// amrr_rate_adaptation
// AMRR transmit-rate controller for one link.
//
// Usage:
//   items   - one item per frame completion, control tick or restart.
//   results - one item per input item, in order: rate index, a changed flag,
//             the success threshold and the recovery flag after that item.
//   cfg     - register writes (min threshold, max threshold, rate count),
//             always ready; write only while no item is in flight.
// Timing: an accepted item is written into the queue, and the back end executes
//   it when popped, registering its result. One item per cycle is sustained
//   while results.ready stays high; the back end's state update sets the rate.
// Stall: a two-entry queue parts the front end from the back end, and the
//   result register holds while results.ready is low. The back end stops
//   when its result cannot move, the queue fills, and items.ready drops.
// Reset: clears the queue and the result register, sets rate 0, counters 0,
//   threshold 1 and the registers to 1, 10 and 12. No clearing pass.
// ----------------------------------------------------------------------------
module amrr_rate_adaptation import amrr_pkg::*; #(
	parameter int COUNT_WIDTH = 16,
	parameter int MAX_RATES   = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	amrr_in_if.sink    items,
	amrr_out_if.source results,
	amrr_cfg_if.sink   cfg
);

	amrr_cfg_t  cfg_q;
	logic       q_push;
	logic       q_full;
	logic       q_valid;
	logic       q_pop;
	amrr_item_t wr_item;
	amrr_item_t rd_item;

	// configuration port: never stalls; writes beyond the list are dropped
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_thr   <= MIN_THR_RST;
			cfg_q.max_thr   <= MAX_THR_RST;
			cfg_q.num_rates <= NUM_RT_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_MIN_THR: cfg_q.min_thr   <= cfg.data;
				CFG_MAX_THR: cfg_q.max_thr   <= cfg.data;
				CFG_NUM_RT:  cfg_q.num_rates <= cfg.data[4:0];
				default: begin
				end
			endcase
		end
	end

	// front end: accept and classify
	amrr_front u_front (
		.items  (items),
		.q_full (q_full),
		.q_push (q_push),
		.q_item (wr_item)
	);

	// hold classified items until the back end is free
	amrr_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_item (wr_item),
		.pop     (q_pop),
		.full    (q_full),
		.valid   (q_valid),
		.rd_item (rd_item)
	);

	// back end: advance link state, register the result
	amrr_back #(
		.COUNT_WIDTH (COUNT_WIDTH),
		.MAX_RATES   (MAX_RATES)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_valid (q_valid),
		.q_item  (rd_item),
		.q_pop   (q_pop),
		.results (results)
	);

endmodule
`default_nettype wire

// ----- test/amrr_rate_adaptation_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amrr_rate_adaptation_tb
// Self-checking bench for the AMRR rate controller. A queue of link events
// (frame completions, control ticks, restarts, unused codes) feeds a driver
// with random gaps. A monitor predicts the rate, threshold and recovery
// flag of every accepted event and checks each result item against it, over
// several register settings and past the threshold at the rate ceiling.
// ----------------------------------------------------------------------------
module amrr_rate_adaptation_tb;
	import amrr_pkg::*;

	localparam int CNT_W       = 16;
	localparam int RATE_SLOTS  = 16;
	localparam int HOLD_CYCLES = 120;
	localparam int MAX_SHOWN   = 40;
	localparam logic [CNT_W-1:0] CNT_FULL = '1;

	typedef struct packed {
		logic [1:0] op;
		logic [3:0] short_retries;
		logic [3:0] long_retries;
		logic [3:0] start_rate;
	} link_event_t;

	typedef struct packed {
		logic [3:0] rate_index;
		logic       rate_changed;
		logic [7:0] threshold;
		logic       in_recovery;
	} rate_result_t;

	logic clk = 1'b0;
	logic arst_n;

	amrr_in_if  items ();
	amrr_out_if results ();
	amrr_cfg_if cfg ();

	amrr_rate_adaptation u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items),
		.results (results),
		.cfg     (cfg)
	);

	always #5 clk = ~clk;

	// event stream waiting for the driver, and results still owed by the block
	link_event_t  pending_events[$];
	rate_result_t rate_results_due[$];

	int n_pushed = 0;
	int n_checked = 0;
	int n_errors = 0;
	int n_rises = 0;
	int n_drops = 0;
	int n_doublings = 0;
	int n_restarts = 0;
	int n_settings = 1;

	// set by the monitor at each rising edge: an item moved on the input side
	logic in_fire = 1'b0;
	// no random gaps on either side while this is set
	logic steady = 1'b0;
	// bump to make the receiver hold off for HOLD_CYCLES
	int hold_requests = 0;

	// predicted link state and register copies
	logic [3:0]       link_rate;
	logic [CNT_W-1:0] frames_sent;
	logic [CNT_W-1:0] frames_retried;
	logic [7:0]       success_run;
	logic [7:0]       success_thr;
	logic             probation;
	logic [7:0]       min_thr;
	logic [7:0]       max_thr;
	logic [4:0]       rate_count;

	// ------------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------------

	// highest usable rate index; a count of zero acts like one
	function automatic logic [3:0] rate_ceiling(logic [4:0] count);
		int lim;
		lim = int'(count);
		if (lim > RATE_SLOTS)
			lim = RATE_SLOTS;
		if (lim > 16)
			lim = 16;
		if (lim == 0)
			lim = 1;
		return 4'(lim - 1);
	endfunction

	// apply one event to the predicted state and form its result item
	task automatic advance_link(input link_event_t ev, output rate_result_t res);
		logic [3:0] prev;
		logic [3:0] top;
		logic       enough;
		logic       good;
		logic       bad;
		logic [8:0] doubled;
		prev = link_rate;
		top = rate_ceiling(rate_count);
		case (ev.op)
			OP_FRAME: begin
				// both counters stick at all ones
				if (frames_sent != CNT_FULL)
					frames_sent++;
				if ((ev.short_retries != 4'd0 || ev.long_retries != 4'd0) &&
					frames_retried != CNT_FULL)
					frames_retried++;
			end
			OP_TICK: begin
				enough = frames_sent > CNT_W'(10);
				good = frames_retried < frames_sent / CNT_W'(10);
				bad = frames_retried > frames_sent / CNT_W'(3);
				if (good && enough) begin
					if (success_run != 8'hFF)
						success_run++;
					// reaching or passing the threshold raises the rate when there is room
					if (success_run >= success_thr && link_rate < top) begin
						probation = 1'b1;
						success_run = 8'd0;
						link_rate = link_rate + 4'd1;
						n_rises++;
					end else begin
						probation = 1'b0;
					end
				end else if (bad) begin
					success_run = 8'd0;
					if (link_rate != 4'd0) begin
						if (probation) begin
							// failed recovery: double, capped at the maximum
							doubled = {success_thr, 1'b0};
							success_thr = (doubled < {1'b0, max_thr}) ? doubled[7:0] : max_thr;
							n_doublings++;
						end else begin
							success_thr = min_thr;
						end
						link_rate = link_rate - 4'd1;
						n_drops++;
					end
					probation = 1'b0;
				end
				if (enough || prev != link_rate) begin
					frames_sent = '0;
					frames_retried = '0;
				end
			end
			OP_RESTART: begin
				link_rate = (ev.start_rate > top) ? top : ev.start_rate;
				frames_sent = '0;
				frames_retried = '0;
				success_run = 8'd0;
				probation = 1'b0;
				success_thr = min_thr;
				n_restarts++;
			end
			default: begin
			end
		endcase
		res.rate_index = link_rate;
		res.rate_changed = (prev != link_rate);
		res.threshold = success_thr;
		res.in_recovery = probation;
	endtask

	task automatic report_mismatch(string msg);
		n_errors++;
		if (n_errors <= MAX_SHOWN)
			$display("%0t mismatch: %s", $realtime, msg);
	endtask

	// ------------------------------------------------------------------------
	// Driver: advance the event queue at the falling edge, hold while stalled
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		link_event_t ev;
		if (arst_n) begin
			if (!items.valid || in_fire) begin
				if (pending_events.size() != 0 && (steady || $urandom_range(99) >= 32)) begin
					ev = pending_events.pop_front();
					items.valid <= 1'b1;
					items.operation <= ev.op;
					items.short_retries <= ev.short_retries;
					items.long_retries <= ev.long_retries;
					items.start_rate <= ev.start_rate;
				end else begin
					items.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off when requested
	always @(negedge clk) begin
		int hold_seen;
		int hold_left;
		if (hold_seen != hold_requests) begin
			hold_seen = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			results.ready <= 1'b0;
		end else begin
			results.ready <= steady || ($urandom_range(99) >= 32);
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: check result items, then predict for the item just accepted
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		rate_result_t got;
		rate_result_t want;
		link_event_t  ev;
		in_fire = arst_n && items.valid && items.ready;
		if (arst_n) begin
			if (results.valid && results.ready) begin
				got.rate_index = results.rate_index;
				got.rate_changed = results.rate_changed;
				got.threshold = results.current_threshold;
				got.in_recovery = results.in_recovery;
				if (rate_results_due.size() == 0) begin
					report_mismatch($sformatf("result with nothing expected: %p", got));
				end else begin
					want = rate_results_due.pop_front();
					if (got.rate_index !== want.rate_index)
						report_mismatch($sformatf("item %0d rate_index %0d, want %0d",
							n_checked, got.rate_index, want.rate_index));
					if (got.rate_changed !== want.rate_changed)
						report_mismatch($sformatf("item %0d rate_changed %0b, want %0b",
							n_checked, got.rate_changed, want.rate_changed));
					if (got.threshold !== want.threshold)
						report_mismatch($sformatf("item %0d current_threshold %0d, want %0d",
							n_checked, got.threshold, want.threshold));
					if (got.in_recovery !== want.in_recovery)
						report_mismatch($sformatf("item %0d in_recovery %0b, want %0b",
							n_checked, got.in_recovery, want.in_recovery));
					n_checked++;
				end
			end
			if (in_fire) begin
				ev.op = items.operation;
				ev.short_retries = items.short_retries;
				ev.long_retries = items.long_retries;
				ev.start_rate = items.start_rate;
				advance_link(ev, want);
				rate_results_due.push_back(want);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	task automatic queue_event(input logic [1:0] op, input logic [3:0] sr,
		input logic [3:0] lr, input logic [3:0] st);
		link_event_t ev;
		ev.op = op;
		ev.short_retries = sr;
		ev.long_retries = lr;
		ev.start_rate = st;
		pending_events.push_back(ev);
		n_pushed++;
	endtask

	// one control interval: exactly retried_n of the frames carry retries,
	// spread at random, then a tick with junk in its unused fields
	task automatic queue_interval(int frames, int retried_n);
		int left;
		logic [3:0] sr;
		logic [3:0] lr;
		left = retried_n;
		for (int i = 0; i < frames; i++) begin
			if (left > 0 && $urandom_range(frames - i - 1) < left) begin
				sr = 4'($urandom_range(15));
				lr = 4'($urandom_range(15));
				if (sr == 4'd0 && lr == 4'd0)
					lr = 4'($urandom_range(15, 1));
				left--;
			end else begin
				sr = 4'd0;
				lr = 4'd0;
			end
			queue_event(OP_FRAME, sr, lr, 4'($urandom_range(15)));
		end
		queue_event(OP_TICK, 4'($urandom_range(15)), 4'($urandom_range(15)),
			4'($urandom_range(15)));
	endtask

	// mostly whole intervals (good, bad or in between), some restarts,
	// lone ticks, stray frames and unused codes
	task automatic queue_random_phase(int budget);
		int made;
		int pick;
		int style;
		int n;
		int r;
		made = 0;
		while (made < budget) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				n = ($urandom_range(9) == 0) ? $urandom_range(10) : $urandom_range(40, 11);
				style = $urandom_range(99);
				if (style < 55)
					r = (n / 10 > 0) ? $urandom_range(n / 10 - 1) : 0;
				else if (style < 85)
					r = (n / 3 + 1 <= n) ? $urandom_range(n, n / 3 + 1) : n;
				else
					r = $urandom_range(n);
				queue_interval(n, r);
				made += n + 1;
			end else if (pick < 80) begin
				queue_event(OP_RESTART, 4'($urandom_range(15)), 4'($urandom_range(15)),
					4'($urandom_range(15)));
				made++;
			end else if (pick < 87) begin
				queue_event(OP_NONE, 4'($urandom_range(15)), 4'($urandom_range(15)),
					4'($urandom_range(15)));
			end else if (pick < 93) begin
				queue_event(OP_TICK, 4'($urandom_range(15)), 4'($urandom_range(15)),
					4'($urandom_range(15)));
				made++;
			end else begin
				repeat ($urandom_range(3, 1)) begin
					queue_event(OP_FRAME, 4'($urandom_range(15)), 4'($urandom_range(15)),
						4'($urandom_range(15)));
					made++;
				end
			end
		end
	endtask

	// wait until every queued event has produced its result
	task automatic settle();
		while (n_checked != n_pushed)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do
			@(posedge clk);
		while (!cfg.ready);
		case (idx)
			CFG_MIN_THR: min_thr = val;
			CFG_MAX_THR: max_thr = val;
			CFG_NUM_RT:  rate_count = val[4:0];
			default: begin
			end
		endcase
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic apply_setting(input logic [7:0] lo, input logic [7:0] hi,
		input logic [7:0] count);
		settle();
		write_reg(CFG_MIN_THR, lo);
		write_reg(CFG_MAX_THR, hi);
		write_reg(CFG_NUM_RT, count);
		n_settings++;
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	initial begin
		items.valid = 1'b0;
		items.operation = OP_FRAME;
		items.short_retries = 4'd0;
		items.long_retries = 4'd0;
		items.start_rate = 4'd0;
		results.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = CFG_MIN_THR;
		cfg.data = '0;
		min_thr = MIN_THR_RST;
		max_thr = MAX_THR_RST;
		rate_count = NUM_RT_RST;
		link_rate = 4'd0;
		frames_sent = '0;
		frames_retried = '0;
		success_run = 8'd0;
		success_thr = MIN_THR_RST;
		probation = 1'b0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: unused code, empty tick, restart clipped to the ceiling,
		// restart to zero, a neutral full interval, a bad short interval at rate zero
		queue_event(OP_NONE, 4'hF, 4'hF, 4'hF);
		queue_event(OP_TICK, 4'h0, 4'h0, 4'h0);
		queue_event(OP_RESTART, 4'h0, 4'h0, 4'hF);
		queue_event(OP_RESTART, 4'hF, 4'hF, 4'h0);
		for (int i = 0; i < 12; i++)
			queue_event(OP_FRAME, (i == 3) ? 4'hF : 4'h0, (i == 7) ? 4'hF : 4'h0, 4'h0);
		queue_event(OP_TICK, 4'hF, 4'hF, 4'hF);
		repeat (3) queue_event(OP_FRAME, 4'h1, 4'h0, 4'h0);
		queue_event(OP_TICK, 4'h0, 4'h0, 4'h0);
		queue_event(OP_RESTART, 4'h0, 4'h0, 4'h5);
		queue_event(OP_NONE, 4'h0, 4'h0, 4'h0);

		// hold the receiver off while the sender keeps offering: the block fills
		hold_requests++;
		queue_random_phase(200);

		// zero threshold at the widest rate set; pause the sender mid-phase
		apply_setting(8'd0, 8'd255, 8'd16);
		queue_random_phase(100);
		settle();
		queue_random_phase(100);

		// single rate, huge minimum, tiny cap
		apply_setting(8'd255, 8'd1, 8'd1);
		queue_random_phase(150);

		// rate count of zero acts like one
		apply_setting(8'd3, 8'd40, 8'd0);
		queue_random_phase(150);

		apply_setting(8'd2, 8'd8, 8'd5);
		queue_random_phase(200);

		// upper data bits are ignored by the rate count
		apply_setting(8'd1, 8'd255, 8'hFF);
		queue_random_phase(200);

		apply_setting(8'd1, 8'd6, 8'd3);
		queue_random_phase(200);

		// a long stretch with no gaps on either side
		apply_setting(8'd1, 8'd10, 8'd16);
		steady = 1'b1;
		queue_random_phase(200);
		settle();
		steady = 1'b0;

		// run the success count past the threshold with no room to rise, then open room
		apply_setting(8'd3, 8'd10, 8'd1);
		queue_event(OP_RESTART, 4'h0, 4'h0, 4'h0);
		repeat (5) queue_interval(12, 0);
		settle();
		write_reg(CFG_NUM_RT, 8'd16);
		queue_interval(12, 0);
		queue_interval(12, 0);

		settle();
		repeat (10) @(posedge clk);
		$display("summary: %0d items checked over %0d register settings", n_checked, n_settings);
		$display("summary: %0d rises, %0d drops, %0d doublings, %0d restarts, %0d mismatches",
			n_rises, n_drops, n_doublings, n_restarts, n_errors);
		if (n_errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run
	initial begin
		#10_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
